/* hw/rtl/risc_instruction_executor_core_defines.svh */
`ifndef RISC_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH
`define RISC_INSTRUCTION_EXECUTOR_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RIE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rie_pkg.sv */
`default_nettype none

package rie_pkg;

    localparam int MEM_DEPTH = 2048;
    localparam int XLEN      = 32;
    localparam int PC_W      = 28;
    localparam int RIDX_W    = 5;
    localparam int MIDX_W    = 11;
    localparam int OP_W      = 4;
    localparam int SH_W      = 13;
    localparam int IMM_W     = 18;
    localparam int SHAMT_LOG = $clog2(XLEN);

    typedef logic [XLEN-1:0]   t_word;
    typedef logic [PC_W-1:0]   t_pc;
    typedef logic [RIDX_W-1:0] t_ridx;
    typedef logic [MIDX_W-1:0] t_midx;
    typedef logic [OP_W-1:0]   t_op;
    typedef logic [SH_W-1:0]   t_sh;

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam t_op OP_ADD  = 4'd0;
    localparam t_op OP_SUB  = 4'd1;
    localparam t_op OP_MULI = 4'd2;
    localparam t_op OP_ADDI = 4'd3;
    localparam t_op OP_BNE  = 4'd4;
    localparam t_op OP_ANDI = 4'd5;
    localparam t_op OP_ORI  = 4'd6;
    localparam t_op OP_J    = 4'd7;
    localparam t_op OP_SLL  = 4'd8;
    localparam t_op OP_SRL  = 4'd9;
    localparam t_op OP_LW   = 4'd10;
    localparam t_op OP_SW   = 4'd11;

    typedef struct packed {
        logic  cmd;
        t_word word;
        t_pc   pc;
        t_midx load_addr;
        t_word load_data;
    } t_item;

    typedef struct packed {
        t_pc   npc;
        logic  br;
        logic  wr;
        t_ridx dest;
        t_word value;
        logic  mw;
        logic  lw;
        logic  bad;
        t_word addr;
    } t_res;

    function automatic t_op f_op(t_word w);
        return w[XLEN-1 -: OP_W];
    endfunction

    function automatic t_ridx f_r1(t_word w);
        return w[XLEN-OP_W-1 -: RIDX_W];
    endfunction

    function automatic t_ridx f_r2(t_word w);
        return w[XLEN-OP_W-RIDX_W-1 -: RIDX_W];
    endfunction

    function automatic t_ridx f_r3(t_word w);
        return w[XLEN-OP_W-2*RIDX_W-1 -: RIDX_W];
    endfunction

    function automatic t_sh f_sh(t_word w);
        return w[SH_W-1:0];
    endfunction

    function automatic t_word f_imm(t_word w);
        return {{(XLEN-IMM_W){w[IMM_W-1]}}, w[IMM_W-1:0]};
    endfunction

    function automatic logic f_uses_a(t_word w);
        return (f_op(w) <= OP_SW) && (f_op(w) != OP_J);
    endfunction

    function automatic logic f_uses_b(t_word w);
        return (f_op(w) == OP_ADD) || (f_op(w) == OP_SUB) ||
               (f_op(w) == OP_BNE) || (f_op(w) == OP_SW);
    endfunction

    function automatic t_ridx f_addr_b(t_word w);
        return ((f_op(w) == OP_ADD) || (f_op(w) == OP_SUB)) ? f_r3(w) : f_r1(w);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rie_if.sv */
`default_nettype none

interface rie_in_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    rie_pkg::t_word                   instr_word;
    rie_pkg::t_pc                     instr_pc;
    rie_pkg::t_midx                   load_addr;
    logic signed [rie_pkg::XLEN-1:0]  load_data;

    modport source (output valid, cmd, instr_word, instr_pc, load_addr, load_data,
                    input ready);
    modport sink   (input valid, cmd, instr_word, instr_pc, load_addr, load_data,
                    output ready);
endinterface

interface rie_out_if;
    logic                             valid;
    logic                             ready;
    rie_pkg::t_pc                     next_pc;
    logic                             branch_taken;
    logic                             reg_written;
    rie_pkg::t_ridx                   dest_reg;
    logic signed [rie_pkg::XLEN-1:0]  write_value;
    logic                             mem_written;
    rie_pkg::t_midx                   mem_index;
    logic                             bad_opcode;

    modport source (output valid, next_pc, branch_taken, reg_written, dest_reg,
                    write_value, mem_written, mem_index, bad_opcode,
                    input ready);
    modport sink   (input valid, next_pc, branch_taken, reg_written, dest_reg,
                    write_value, mem_written, mem_index, bad_opcode,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/rie_regfile.sv */
`default_nettype none

module rie_regfile (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rie_pkg::t_ridx i_raddr_a,
    input  wire rie_pkg::t_ridx i_raddr_b,
    input  wire logic           i_we,
    input  wire rie_pkg::t_ridx i_waddr,
    input  wire rie_pkg::t_word i_wdata,
    output rie_pkg::t_word      o_rdata_a,
    output rie_pkg::t_word      o_rdata_b
);

    localparam int DEPTH = 1 << rie_pkg::RIDX_W;

    rie_pkg::t_word   r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    rie_pkg::t_word   r_q_a;
    rie_pkg::t_word   r_q_b;
    logic             r_qv_a;
    logic             r_qv_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q_a  <= r_mem[i_raddr_a];
        r_q_b  <= r_mem[i_raddr_b];
        r_qv_a <= r_valid[i_raddr_a];
        r_qv_b <= r_valid[i_raddr_b];
    end

    assign o_rdata_a = r_qv_a ? r_q_a : '0;
    assign o_rdata_b = r_qv_b ? r_q_b : '0;

endmodule

`default_nettype wire

/* hw/rtl/rie_dmem.sv */
`default_nettype none

module rie_dmem #(
    parameter int MEM_DEPTH = rie_pkg::MEM_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic                         i_re,
    input  wire logic [$clog2(MEM_DEPTH)-1:0] i_addr,
    input  wire rie_pkg::t_word               i_wdata,
    output rie_pkg::t_word                    o_rdata,
    output logic                              o_clearing
);

    localparam int                 AW   = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0]      LAST = AW'(MEM_DEPTH - 1);

    rie_pkg::t_word r_mem [MEM_DEPTH];
    rie_pkg::t_word r_q;
    logic           r_clearing;
    logic [AW-1:0]  r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_q;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

/* hw/rtl/rie_exec.sv */
`default_nettype none

module rie_exec (
    input  wire rie_pkg::t_item i_item,
    input  wire rie_pkg::t_word i_va,
    input  wire rie_pkg::t_word i_vb,
    output rie_pkg::t_res       o_res
);

    rie_pkg::t_op   op;
    rie_pkg::t_word imm;
    rie_pkg::t_sh   sh;
    logic           sh_big;

    assign op     = rie_pkg::f_op(i_item.word);
    assign imm    = rie_pkg::f_imm(i_item.word);
    assign sh     = rie_pkg::f_sh(i_item.word);
    assign sh_big = (sh[rie_pkg::SH_W-1:rie_pkg::SHAMT_LOG] != '0);

    always_comb begin
        o_res = '0;
        if (i_item.cmd == rie_pkg::CMD_LOAD) begin
            o_res.mw    = 1'b1;
            o_res.value = i_item.load_data;
            o_res.addr  = rie_pkg::t_word'(i_item.load_addr);
        end else begin
            o_res.npc  = i_item.pc + 1'b1;
            o_res.addr = i_va + imm;
            unique case (op)
                rie_pkg::OP_ADD: begin
                    o_res.wr    = 1'b1;
                    o_res.value = i_va + i_vb;
                end
                rie_pkg::OP_SUB: begin
                    o_res.wr    = 1'b1;
                    o_res.value = i_va - i_vb;
                end
                rie_pkg::OP_MULI: begin
                    o_res.wr    = 1'b1;
                    o_res.value = i_va * imm;
                end
                rie_pkg::OP_ADDI: begin
                    o_res.wr    = 1'b1;
                    o_res.value = i_va + imm;
                end
                rie_pkg::OP_BNE: begin
                    if (i_vb != i_va) begin
                        o_res.npc = i_item.pc + 1'b1 + imm[rie_pkg::PC_W-1:0];
                        o_res.br  = 1'b1;
                    end
                end
                rie_pkg::OP_ANDI: begin
                    o_res.wr    = 1'b1;
                    o_res.value = i_va & imm;
                end
                rie_pkg::OP_ORI: begin
                    o_res.wr    = 1'b1;
                    o_res.value = i_va | imm;
                end
                rie_pkg::OP_J: begin
                    o_res.npc = i_item.word[rie_pkg::PC_W-1:0];
                    o_res.br  = 1'b1;
                end
                rie_pkg::OP_SLL: begin
                    o_res.wr    = 1'b1;
                    o_res.value = sh_big ? '0 : (i_va << sh[rie_pkg::SHAMT_LOG-1:0]);
                end
                rie_pkg::OP_SRL: begin
                    o_res.wr    = 1'b1;
                    o_res.value = sh_big ? '0 : (i_va >> sh[rie_pkg::SHAMT_LOG-1:0]);
                end
                rie_pkg::OP_LW: begin
                    o_res.wr = 1'b1;
                    o_res.lw = 1'b1;
                end
                rie_pkg::OP_SW: begin
                    o_res.mw    = 1'b1;
                    o_res.value = i_vb;
                end
                default: begin
                    o_res.bad = 1'b1;
                end
            endcase
            o_res.dest = o_res.wr ? rie_pkg::f_r1(i_item.word) : '0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/risc_instruction_executor_core.sv */
// Pipeline: an accepted transaction passes through the execute, address reduce, memory access
//   and result registers in order; back-pressure on the output can hold it in any of them.
// Throughput: one instruction per cycle while the output is ready; an instruction that uses
//   a load result of one of the two before it waits in execute until the load data leaves memory.
// Reset: synchronous, active low; input stays not ready while the data memory is zeroed;
//   registers read as zero until written.
`default_nettype none

`include "risc_instruction_executor_core_defines.svh"

module risc_instruction_executor_core #(
    parameter int MEM_DEPTH = rie_pkg::MEM_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rie_in_if.sink     i_in,
    rie_out_if.source  o_out
);

    localparam int                      XLEN       = rie_pkg::XLEN;
    localparam int                      MEM_AW     = $clog2(MEM_DEPTH);
    localparam int                      RECIP_SH   = XLEN + MEM_AW;
    localparam logic [63:0]             RECIP_FULL = (64'd1 << RECIP_SH) / MEM_DEPTH;
    localparam logic [XLEN:0]           RECIP      = RECIP_FULL[XLEN:0];
    localparam logic [MEM_AW:0]         DEPTH_X    = (MEM_AW + 1)'(MEM_DEPTH);
    localparam rie_pkg::t_word          DEPTH_W    = rie_pkg::t_word'(MEM_DEPTH);

    rie_pkg::t_item       item_in;
    rie_pkg::t_item       rd_item;
    rie_pkg::t_item       r_s1;
    rie_pkg::t_res        s1_res;
    rie_pkg::t_res        r_s2;
    rie_pkg::t_res        r_s3;
    rie_pkg::t_res        r_s4;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    logic                 r_v4;
    rie_pkg::t_word       r_q3;
    logic [MEM_AW-1:0]    r_idx4;

    logic                 r_wb_v;
    rie_pkg::t_ridx       r_wb_dest;
    rie_pkg::t_word       r_wb_value;

    rie_pkg::t_ridx       rf_addr_a;
    rie_pkg::t_ridx       rf_addr_b;
    rie_pkg::t_word       rf_q_a;
    rie_pkg::t_word       rf_q_b;
    rie_pkg::t_ridx       op_addr [2];
    rie_pkg::t_word       op_rf   [2];
    rie_pkg::t_word       op_val  [2];
    logic                 op_haz  [2];
    logic                 hazard;

    logic [2*XLEN:0]      prod;
    rie_pkg::t_word       q_next;
    rie_pkg::t_word       qd;
    rie_pkg::t_word       diff;
    logic [MEM_AW:0]      dsub;
    logic [MEM_AW-1:0]    mem_idx;
    logic                 mem_we;
    logic                 mem_re;
    rie_pkg::t_word       mem_q;
    logic                 dm_clearing;

    logic                 s4_free;
    logic                 s3_free;
    logic                 s3_go;
    logic                 s2_free;
    logic                 s1_go;
    logic                 s1_free;
    logic                 in_fire;
    logic                 out_fire;
    rie_pkg::t_word       out_wvalue;

    assign item_in.cmd       = i_in.cmd;
    assign item_in.word      = i_in.instr_word;
    assign item_in.pc        = i_in.instr_pc;
    assign item_in.load_addr = i_in.load_addr;
    assign item_in.load_data = i_in.load_data;

    assign s4_free = !r_v4 || o_out.ready;
    assign s3_free = !r_v3 || s4_free;
    assign s3_go   = r_v3 && s4_free;
    assign s2_free = !r_v2 || s3_free;
    assign s1_go   = r_v1 && !hazard && s2_free;
    assign s1_free = !r_v1 || s1_go;

    assign i_in.ready = s1_free && !dm_clearing;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = r_v4 && o_out.ready;

    // re-read the held instruction's operands every cycle while it waits
    assign rd_item   = s1_free ? item_in : r_s1;
    assign rf_addr_a = rie_pkg::f_r2(rd_item.word);
    assign rf_addr_b = rie_pkg::f_addr_b(rd_item.word);

    rie_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (rf_addr_a),
        .i_raddr_b (rf_addr_b),
        .i_we      (out_fire && r_s4.wr),
        .i_waddr   (r_s4.dest),
        .i_wdata   (out_wvalue),
        .o_rdata_a (rf_q_a),
        .o_rdata_b (rf_q_b)
    );

    assign op_addr[0] = rie_pkg::f_r2(r_s1.word);
    assign op_addr[1] = rie_pkg::f_addr_b(r_s1.word);
    assign op_rf[0]   = rf_q_a;
    assign op_rf[1]   = rf_q_b;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            op_haz[k] = 1'b0;
            priority if (r_v2 && r_s2.wr && (r_s2.dest == op_addr[k])) begin
                op_haz[k] = r_s2.lw;
                op_val[k] = r_s2.value;
            end else if (r_v3 && r_s3.wr && (r_s3.dest == op_addr[k])) begin
                op_haz[k] = r_s3.lw;
                op_val[k] = r_s3.value;
            end else if (r_v4 && r_s4.wr && (r_s4.dest == op_addr[k])) begin
                op_val[k] = out_wvalue;
            end else if (r_wb_v && (r_wb_dest == op_addr[k])) begin
                op_val[k] = r_wb_value;
            end else begin
                op_val[k] = op_rf[k];
            end
        end
    end

    assign hazard = r_v1 && (r_s1.cmd == rie_pkg::CMD_EXEC) &&
                    ((rie_pkg::f_uses_a(r_s1.word) && op_haz[0]) ||
                     (rie_pkg::f_uses_b(r_s1.word) && op_haz[1]));

    rie_exec u_exec (
        .i_item (r_s1),
        .i_va   (op_val[0]),
        .i_vb   (op_val[1]),
        .o_res  (s1_res)
    );

    assign prod   = {{(XLEN + 1){1'b0}}, r_s2.addr} * {{XLEN{1'b0}}, RECIP};
    assign q_next = rie_pkg::t_word'(prod >> RECIP_SH);

    assign qd      = r_q3 * DEPTH_W;
    assign diff    = r_s3.addr - qd;
    assign dsub    = diff[MEM_AW:0] - DEPTH_X;
    assign mem_idx = (diff[MEM_AW:0] >= DEPTH_X) ? dsub[MEM_AW-1:0] : diff[MEM_AW-1:0];
    assign mem_we  = s3_go && r_s3.mw;
    assign mem_re  = s3_go && r_s3.lw;

    rie_dmem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (mem_we),
        .i_re       (mem_re),
        .i_addr     (mem_idx),
        .i_wdata    (r_s3.value),
        .o_rdata    (mem_q),
        .o_clearing (dm_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_wb_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= in_fire;
            end
            if (s2_free) begin
                r_v2 <= s1_go;
            end
            if (s3_free) begin
                r_v3 <= r_v2;
            end
            if (s4_free) begin
                r_v4 <= r_v3;
            end
            if (out_fire && r_s4.wr) begin
                r_wb_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= item_in;
        end
        if (s2_free) begin
            r_s2 <= s1_res;
        end
        if (s3_free) begin
            r_s3 <= r_s2;
            r_q3 <= q_next;
        end
        if (s4_free) begin
            r_s4   <= r_s3;
            r_idx4 <= mem_idx;
        end
        if (out_fire && r_s4.wr) begin
            r_wb_dest  <= r_s4.dest;
            r_wb_value <= out_wvalue;
        end
    end

    assign out_wvalue = r_s4.lw ? mem_q : r_s4.value;

    assign o_out.valid        = r_v4;
    assign o_out.next_pc      = r_s4.npc;
    assign o_out.branch_taken = r_s4.br;
    assign o_out.reg_written  = r_s4.wr;
    assign o_out.dest_reg     = r_s4.dest;
    assign o_out.write_value  = out_wvalue;
    assign o_out.mem_written  = r_s4.mw;
    assign o_out.mem_index    = (r_s4.lw || r_s4.mw) ? rie_pkg::t_midx'(r_idx4) : '0;
    assign o_out.bad_opcode   = r_s4.bad;

    `RIE_ASSERT_IMPL(a_empty_while_clearing, i_clk, i_rst_n, dm_clearing, !r_v1 && !r_v2 && !r_v3 && !r_v4, "instruction in flight during memory clear")
    `RIE_ASSERT_IMPL(a_mem_port_exclusive, i_clk, i_rst_n, mem_we, !mem_re, "data memory read and write in one cycle")
    `RIE_ASSERT_NEXT(a_load_use_bubble, i_clk, i_rst_n, r_v1 && hazard && s2_free, !r_v2, "load-use interlock did not insert a bubble")
    `RIE_ASSERT_IMPL(a_load_writes_reg, i_clk, i_rst_n, r_v4 && r_s4.lw, r_s4.wr && !r_s4.mw, "load result without register write")

endmodule

`default_nettype wire

/* verif/risc_instruction_executor_core_test.sv */
`default_nettype none

module risc_instruction_executor_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rie_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1000;
    localparam int IDLE_PCT = 13;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
        t_pc   next_pc;
        logic  taken;
        logic  reg_wr;
        t_ridx dest;
        t_word value;
        logic  mem_wr;
        t_midx mem_idx;
        logic  bad;
    } t_outcome;

    class exec_scoreboard;
        t_word    regs [32];
        t_word    mem [MEM_DEPTH];
        t_outcome pending [$];
        int       fails;
        int       seen;

        function new();
            fails = 0;
            seen = 0;
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
        endfunction

        function void note(t_item it);
            t_outcome o;
            t_op      op;
            t_ridx    r1, r2, r3;
            t_sh      sh;
            t_word    a, b, c, imm, res, sum;
            logic     wr;
            o = '0;
            if (it.cmd == CMD_LOAD) begin
                o.mem_wr = 1'b1;
                o.mem_idx = t_midx'(it.load_addr % MEM_DEPTH);
                o.value = it.load_data;
                mem[o.mem_idx] = it.load_data;
            end else begin
                op = it.word[31:28];
                r1 = it.word[27:23];
                r2 = it.word[22:18];
                r3 = it.word[17:13];
                sh = it.word[12:0];
                imm = {{(XLEN-IMM_W){it.word[IMM_W-1]}}, it.word[IMM_W-1:0]};
                a = regs[r1];
                b = regs[r2];
                c = regs[r3];
                wr = 1'b1;
                res = '0;
                o.next_pc = it.pc + t_pc'(1);
                case (op)
                    OP_ADD:  res = b + c;
                    OP_SUB:  res = b - c;
                    OP_MULI: res = b * imm;
                    OP_ADDI: res = b + imm;
                    OP_BNE: begin
                        wr = 1'b0;
                        if (a != b) begin
                            o.next_pc = it.pc + t_pc'(1) + imm[PC_W-1:0];
                            o.taken = 1'b1;
                        end
                    end
                    OP_ANDI: res = b & imm;
                    OP_ORI:  res = b | imm;
                    OP_J: begin
                        wr = 1'b0;
                        o.next_pc = it.word[PC_W-1:0];
                        o.taken = 1'b1;
                    end
                    OP_SLL:  res = (sh < XLEN) ? (b << sh) : '0;
                    OP_SRL:  res = (sh < XLEN) ? (b >> sh) : '0;
                    OP_LW: begin
                        sum = b + imm;
                        o.mem_idx = t_midx'(sum % MEM_DEPTH);
                        res = mem[o.mem_idx];
                    end
                    OP_SW: begin
                        wr = 1'b0;
                        sum = b + imm;
                        o.mem_idx = t_midx'(sum % MEM_DEPTH);
                        mem[o.mem_idx] = a;
                        o.mem_wr = 1'b1;
                        o.value = a;
                    end
                    default: begin
                        wr = 1'b0;
                        o.bad = 1'b1;
                    end
                endcase
                if (wr) begin
                    regs[r1] = res;
                    o.reg_wr = 1'b1;
                    o.dest = r1;
                    o.value = res;
                end
            end
            pending.push_back(o);
        endfunction

        task report(string field, t_word got, t_word want);
            fails++;
            if (fails <= MAX_PRINTED)
                $display("result %0d: %s is %h, expected %h", seen, field, got, want);
        endtask

        task check(t_outcome got);
            t_outcome want;
            seen++;
            if (pending.size() == 0) begin
                report("unexpected transaction, value", got.value, '0);
                return;
            end
            want = pending.pop_front();
            if (got.next_pc != want.next_pc)
                report("next_pc", t_word'(got.next_pc), t_word'(want.next_pc));
            if (got.taken != want.taken)
                report("branch_taken", t_word'(got.taken), t_word'(want.taken));
            if (got.reg_wr != want.reg_wr)
                report("reg_written", t_word'(got.reg_wr), t_word'(want.reg_wr));
            if (got.dest != want.dest)
                report("dest_reg", t_word'(got.dest), t_word'(want.dest));
            if (got.value != want.value) report("write_value", got.value, want.value);
            if (got.mem_wr != want.mem_wr)
                report("mem_written", t_word'(got.mem_wr), t_word'(want.mem_wr));
            if (got.mem_idx != want.mem_idx)
                report("mem_index", t_word'(got.mem_idx), t_word'(want.mem_idx));
            if (got.bad != want.bad)
                report("bad_opcode", t_word'(got.bad), t_word'(want.bad));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   n_in = 0;
    int   cycles = 0;
    bit   held = 1'b0;

    exec_scoreboard sb;

    rie_in_if  instr_ch ();
    rie_out_if result_ch ();

    risc_instruction_executor_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("risc_instruction_executor_core_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            sb.check({result_ch.next_pc, result_ch.branch_taken, result_ch.reg_written,
                      result_ch.dest_reg, result_ch.write_value, result_ch.mem_written,
                      result_ch.mem_index, result_ch.bad_opcode});
    end

    function automatic bit calm();
        return n_in >= 150 && n_in < 350;
    endfunction

    // hold off once for a long stretch so the core fills up
    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_in >= HOLD_AT) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (calm()) begin
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send(t_item it);
        @(negedge i_clk);
        while (!calm() && $urandom_range(99) < IDLE_PCT) begin
            instr_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.cmd <= it.cmd;
        instr_ch.instr_word <= it.word;
        instr_ch.instr_pc <= it.pc;
        instr_ch.load_addr <= it.load_addr;
        instr_ch.load_data <= it.load_data;
        do @(posedge i_clk); while (!(instr_ch.valid && instr_ch.ready));
        sb.note(it);
        n_in++;
    endtask

    task automatic exec(t_word w, t_pc pc);
        t_item it;
        it.cmd = CMD_EXEC;
        it.word = w;
        it.pc = pc;
        it.load_addr = t_midx'($urandom);
        it.load_data = $urandom;
        send(it);
    endtask

    task automatic preload(t_midx addr, t_word data);
        t_item it;
        it.cmd = CMD_LOAD;
        it.word = $urandom;
        it.pc = t_pc'($urandom);
        it.load_addr = addr;
        it.load_data = data;
        send(it);
    endtask

    function automatic t_word enc_i(t_op op, t_ridx r1, t_ridx r2, logic [IMM_W-1:0] imm);
        return {op, r1, r2, imm};
    endfunction

    function automatic t_word enc_r(t_op op, t_ridx r1, t_ridx r2, t_ridx r3, t_sh sh);
        return {op, r1, r2, r3, sh};
    endfunction

    function automatic t_ridx pick_reg();
        return ($urandom_range(99) < 50) ? t_ridx'($urandom_range(3)) : t_ridx'($urandom);
    endfunction

    function automatic t_item rand_item();
        t_item it;
        t_op   op;
        t_ridx r1, r2, r3;
        t_word w;
        t_midx target;
        it.cmd = CMD_EXEC;
        it.word = $urandom;
        it.pc = t_pc'($urandom);
        it.load_addr = t_midx'($urandom);
        it.load_data = $urandom;
        if ($urandom_range(99) < 4)
            it.pc = '1;
        if ($urandom_range(99) < 10) begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(99) < 70)
                it.load_addr = t_midx'($urandom_range(63));
            return it;
        end
        op = ($urandom_range(99) < 6) ? t_op'($urandom_range(15, 12)) : t_op'($urandom_range(11));
        r1 = pick_reg();
        r2 = pick_reg();
        r3 = pick_reg();
        if (op == OP_BNE && $urandom_range(99) < 30)
            r2 = r1;
        w = enc_r(op, r1, r2, r3, it.word[SH_W-1:0]);
        if ((op == OP_SLL || op == OP_SRL) && $urandom_range(99) < 70)
            w[SH_W-1:0] = t_sh'($urandom_range(XLEN));
        // steer most memory accesses into a small window that preloads also hit
        if ((op == OP_LW || op == OP_SW) && $urandom_range(99) < 70) begin
            target = t_midx'($urandom_range(63));
            w[MIDX_W-1:0] = target - sb.regs[r2][MIDX_W-1:0];
        end
        it.word = w;
        return it;
    endfunction

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        instr_ch.valid = 1'b0;
        instr_ch.cmd = CMD_EXEC;
        instr_ch.instr_word = '0;
        instr_ch.instr_pc = '0;
        instr_ch.load_addr = '0;
        instr_ch.load_data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        preload('0, 32'h8000_0000);
        preload('1, 32'h7FFF_FFFF);
        preload(t_midx'(5), 32'hFFFF_FFFF);
        exec(enc_i(OP_LW, 5'd1, 5'd0, 18'd2047), t_pc'(0));
        exec(enc_i(OP_LW, 5'd2, 5'd0, 18'h3F800), t_pc'(1));
        exec(enc_r(OP_ADD, 5'd3, 5'd1, 5'd2, '0), t_pc'(2));
        exec(enc_r(OP_SUB, 5'd4, 5'd2, 5'd1, '1), t_pc'(3));
        exec(enc_i(OP_MULI, 5'd5, 5'd1, 18'h3FFFF), t_pc'(4));
        exec(enc_i(OP_ADDI, 5'd0, 5'd0, 18'h1FFFF), t_pc'(5));
        exec(enc_i(OP_ANDI, 5'd6, 5'd3, 18'h20000), t_pc'(6));
        exec(enc_i(OP_ORI, 5'd7, 5'd0, 18'h3FFFF), t_pc'(7));
        exec(enc_i(OP_BNE, 5'd1, 5'd2, 18'd5), '1);
        exec(enc_i(OP_BNE, 5'd1, 5'd1, 18'h3FFFF), '1);
        exec({OP_J, 28'hFFF_FFFF}, t_pc'(8));
        exec({OP_J, 28'h000_0000}, '1);
        exec(enc_r(OP_SLL, 5'd8, 5'd1, 5'd31, t_sh'(0)), t_pc'(9));
        exec(enc_r(OP_SLL, 5'd9, 5'd1, 5'd0, t_sh'(31)), t_pc'(10));
        exec(enc_r(OP_SLL, 5'd10, 5'd1, 5'd0, t_sh'(32)), t_pc'(11));
        exec(enc_r(OP_SRL, 5'd11, 5'd2, 5'd0, t_sh'(31)), t_pc'(12));
        exec(enc_r(OP_SRL, 5'd12, 5'd2, 5'd0, '1), t_pc'(13));
        exec(enc_i(OP_SW, 5'd3, 5'd4, 18'd100), t_pc'(14));
        exec(enc_i(OP_LW, 5'd13, 5'd4, 18'd100), t_pc'(15));
        exec(enc_r(OP_ADD, 5'd14, 5'd13, 5'd13, '0), t_pc'(16));
        exec(32'hC000_0000, t_pc'(17));
        exec('1, '1);

        repeat (RANDOM_ITEMS) send(rand_item());

        @(negedge i_clk);
        instr_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0)
            $display("risc_instruction_executor_core_test OK");
        else
            $display("risc_instruction_executor_core_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rie_pkg.sv
hw/rtl/rie_if.sv
hw/rtl/rie_regfile.sv
hw/rtl/rie_dmem.sv
hw/rtl/rie_exec.sv
hw/rtl/risc_instruction_executor_core.sv
verif/risc_instruction_executor_core_test.sv
